@@ rtl/core/rgbyuv_pkg.sv @@
// Shared types and constants for the RGB to YUV 4:2:0 pixel writer.
// Used by rgbyuv_color, rgbyuv_addr and the top level; no dependencies.

package rgbyuv_pkg;

    // Field widths
    localparam int unsigned COMP_W   = 8;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned LADDR_W  = 24;
    localparam int unsigned CADDR_W  = 25;
    localparam int unsigned CFG_IDX_W = 2;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 104;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_LAYOUT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Chroma layout codes
    localparam logic LAYOUT_SEMI_PLANAR = 1'b0;
    localparam logic LAYOUT_PLANAR      = 1'b1;

    // BT.601 studio-range integer weights
    localparam logic [7:0]  Y_R = 8'd66;
    localparam logic [7:0]  Y_G = 8'd129;
    localparam logic [7:0]  Y_B = 8'd25;
    localparam logic [7:0]  U_R = 8'd38;   // subtracted
    localparam logic [7:0]  U_G = 8'd74;   // subtracted
    localparam logic [7:0]  U_B = 8'd112;
    localparam logic [7:0]  V_R = 8'd112;
    localparam logic [7:0]  V_G = 8'd94;   // subtracted
    localparam logic [7:0]  V_B = 8'd18;   // subtracted
    localparam logic [15:0] ROUND_HALF  = 16'd128;
    localparam logic [7:0]  LUMA_OFFSET = 8'd16;
    // Rounding plus a 128 bias held at bit 8, so chroma sums stay non-negative
    localparam logic [16:0] CHROMA_BIAS = 17'd32896;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             chroma_layout;
    } cfg_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] u;
        logic [COMP_W-1:0] v;
    } yuv_t;

    typedef struct packed {
        logic [LADDR_W-1:0] luma_address;
        logic               chroma_write;
        logic [CADDR_W-1:0] u_address;
        logic [CADDR_W-1:0] v_address;
    } addr_t;

endpackage

@@ rtl/core/rgb_to_yuv420_pixel_writer_unit.sv @@
// Top level of the RGB to YUV 4:2:0 pixel writer: stream ports, config and pipeline.
// Instantiates rgbyuv_color and rgbyuv_addr; uses rgbyuv_pkg.

// One pixel beat in, one result beat out, one beat per clock while the output is
// free or taken. The pipeline holds an input register, a stage of products
// (frame_width*row and the chroma row product) with the color conversion, then the
// output register holding the final address sums. The whole pipeline advances
// together when the output register is empty or taken, so s_axis_tready follows
// m_axis_tready in the same cycle. Chroma bytes and addresses are present only on
// the top-left pixel of each 2x2 block (m_axis_tuser high) and read zero otherwise.
// Write the configuration registers only while no beat is in flight.

module rgb_to_yuv420_pixel_writer_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration writes
    input  logic                                   cfg_we,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rgbyuv_pkg::DIM_W-1:0]           cfg_data,
    // Pixel input
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // red[7:0], green[15:8], blue[23:16], column[35:24], row[47:36]
    input  logic [rgbyuv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Result output
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // luma_value[7:0], luma_address[31:8], u_value[39:32], v_value[47:40],
    // u_address[72:48], v_address[97:73], zero[103:98]
    output logic [rgbyuv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // chroma_write[0]
    output logic                                   m_axis_tuser
);

    rgbyuv_pkg::cfg_t                  cfg_reg;
    logic                              en;
    logic                              a_valid_reg;
    logic                              b_valid_reg;
    logic                              c_valid_reg;
    rgbyuv_pkg::rgb_t                  rgb_a_reg;
    logic [rgbyuv_pkg::POS_W-1:0]      col_a_reg;
    logic [rgbyuv_pkg::POS_W-1:0]      row_a_reg;
    logic                              even_a;
    rgbyuv_pkg::yuv_t                  yuv_a;
    rgbyuv_pkg::yuv_t                  yuv_b_reg;
    rgbyuv_pkg::yuv_t                  yuv_c_reg;
    logic                              even_b_reg;
    rgbyuv_pkg::addr_t                 addr_c;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= rgbyuv_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= rgbyuv_pkg::FRAME_HEIGHT_RST;
            cfg_reg.chroma_layout <= rgbyuv_pkg::LAYOUT_SEMI_PLANAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rgbyuv_pkg::REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data;
                rgbyuv_pkg::REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data;
                rgbyuv_pkg::REG_CHROMA_LAYOUT: cfg_reg.chroma_layout <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // Advance the whole pipeline when the output register is free or drained
    assign en            = ~c_valid_reg | m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Input register: capture the pixel beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rgb_a_reg.red   <= s_axis_tdata[7:0];
            rgb_a_reg.green <= s_axis_tdata[15:8];
            rgb_a_reg.blue  <= s_axis_tdata[23:16];
            col_a_reg       <= s_axis_tdata[35:24];
            row_a_reg       <= s_axis_tdata[47:36];
        end
    end

    rgbyuv_color u_color
    (
        .rgb (rgb_a_reg),
        .yuv (yuv_a)
    );

    rgbyuv_addr u_addr
    (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg_reg),
        .column (col_a_reg),
        .row    (row_a_reg),
        .addr   (addr_c)
    );

    assign even_a = ~col_a_reg[0] & ~row_a_reg[0];

    // Carry the color bytes alongside the address stages; drop chroma off the 2x2 corner
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yuv_b_reg     <= yuv_a;
            even_b_reg    <= even_a;
            yuv_c_reg.y   <= yuv_b_reg.y;
            yuv_c_reg.u   <= even_b_reg ? yuv_b_reg.u : '0;
            yuv_c_reg.v   <= even_b_reg ? yuv_b_reg.v : '0;
        end
    end

    // Result beat
    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tuser  = addr_c.chroma_write;
    assign m_axis_tdata  = {6'd0, addr_c.v_address, addr_c.u_address,
                            yuv_c_reg.v, yuv_c_reg.u, addr_c.luma_address, yuv_c_reg.y};

    // Non-corner pixels carry no chroma bytes or addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[97:32] == '0))
        else $error("chroma fields not cleared on a pixel without chroma");

    // Luma stays within studio range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd235))
        else $error("luma value outside studio range");

    // Chroma bytes stay within studio range on corner pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[39:32] >= 8'd16 && m_axis_tdata[39:32] <= 8'd240 &&
             m_axis_tdata[47:40] >= 8'd16 && m_axis_tdata[47:40] <= 8'd240))
        else $error("chroma value outside studio range");

endmodule

@@ rtl/core/rgbyuv_color.sv @@
// Color conversion: one RGB pixel to BT.601 studio-range Y, U and V bytes.
// Pure combinational logic; depends on rgbyuv_pkg.

module rgbyuv_color
(
    input  rgbyuv_pkg::rgb_t rgb,
    output rgbyuv_pkg::yuv_t yuv
);

    logic [15:0] r16;
    logic [15:0] g16;
    logic [15:0] b16;
    logic [15:0] y_sum;
    logic [16:0] u_sum;
    logic [16:0] v_sum;

    assign r16 = {8'd0, rgb.red};
    assign g16 = {8'd0, rgb.green};
    assign b16 = {8'd0, rgb.blue};

    // Weighted luma sum with rounding, at most 56228
    assign y_sum = 16'(r16 * 16'(rgbyuv_pkg::Y_R)) + 16'(g16 * 16'(rgbyuv_pkg::Y_G))
                 + 16'(b16 * 16'(rgbyuv_pkg::Y_B)) + rgbyuv_pkg::ROUND_HALF;

    // Chroma sums carry the 128 offset at bit 8 and stay within 16 bits
    assign u_sum = rgbyuv_pkg::CHROMA_BIAS
                 + 17'(b16 * 16'(rgbyuv_pkg::U_B))
                 - 17'(r16 * 16'(rgbyuv_pkg::U_R))
                 - 17'(g16 * 16'(rgbyuv_pkg::U_G));
    assign v_sum = rgbyuv_pkg::CHROMA_BIAS
                 + 17'(r16 * 16'(rgbyuv_pkg::V_R))
                 - 17'(g16 * 16'(rgbyuv_pkg::V_G))
                 - 17'(b16 * 16'(rgbyuv_pkg::V_B));

    // Take the integer part and add the luma offset
    assign yuv.y = y_sum[15:8] + rgbyuv_pkg::LUMA_OFFSET;
    assign yuv.u = u_sum[15:8];
    assign yuv.v = v_sum[15:8];

endmodule

@@ rtl/core/rgbyuv_addr.sv @@
// Frame-buffer address unit: luma and 4:2:0 chroma byte offsets, two stages.
// Products are registered in the first stage, sums in the second; uses rgbyuv_pkg.

module rgbyuv_addr
(
    input  logic                                clk,
    input  logic                                en,
    input  rgbyuv_pkg::cfg_t                    cfg,
    input  logic [rgbyuv_pkg::POS_W-1:0]        column,
    input  logic [rgbyuv_pkg::POS_W-1:0]        row,
    output rgbyuv_pkg::addr_t                   addr
);

    logic [13:0]                      half_width_sum;
    logic [12:0]                      half_width;
    logic [25:0]                      size_reg;
    logic [24:0]                      luma_prod_reg;
    logic [23:0]                      k_prod_reg;
    logic [rgbyuv_pkg::POS_W-1:0]     col_b_reg;
    logic                             even_b_reg;
    logic [26:0]                      k_ext;
    logic [26:0]                      size_ext;
    logic [26:0]                      u_base;
    logic [26:0]                      u_sum;
    logic [26:0]                      v_sum;
    rgbyuv_pkg::addr_t                addr_next;
    rgbyuv_pkg::addr_t                addr_reg;

    // Chroma row pitch in samples: (frame_width + 1) / 2
    assign half_width_sum = {1'b0, cfg.frame_width} + 14'd1;
    assign half_width     = half_width_sum[13:1];

    // Frame size tracks cfg; the user is to write it only while idle, unenforced
    always_ff @(posedge clk)
    begin
        size_reg <= 26'(cfg.frame_width) * 26'(cfg.frame_height);
    end

    // Stage one: hold the multiplications
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            luma_prod_reg <= 25'(cfg.frame_width) * 25'(row);
            k_prod_reg    <= 24'(row[rgbyuv_pkg::POS_W-1:1]) * 24'(half_width);
            col_b_reg     <= column;
            even_b_reg    <= ~column[0] & ~row[0];
        end
    end

    // Stage two: chroma sample index and plane offsets
    assign k_ext    = 27'(k_prod_reg) + 27'(col_b_reg[rgbyuv_pkg::POS_W-1:1]);
    assign size_ext = {1'b0, size_reg};
    assign u_base   = (cfg.chroma_layout == rgbyuv_pkg::LAYOUT_PLANAR)
                    ? size_ext + {2'b00, size_ext[26:2]} : size_ext;

    always_comb
    begin
        if (cfg.chroma_layout == rgbyuv_pkg::LAYOUT_PLANAR)
        begin
            u_sum = u_base + k_ext;
            v_sum = size_ext + k_ext;
        end
        else
        begin
            u_sum = u_base + {k_ext[25:0], 1'b0};
            v_sum = u_base + {k_ext[25:0], 1'b1};
        end
        addr_next.luma_address = 24'(luma_prod_reg + 25'(col_b_reg));
        addr_next.chroma_write = even_b_reg;
        addr_next.u_address    = even_b_reg ? u_sum[24:0] : '0;
        addr_next.v_address    = even_b_reg ? v_sum[24:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

@@ verif/rgb_to_yuv420_pixel_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_yuv420_pixel_writer_unit: BT.601 color conversion
// and 4:2:0 frame buffer addressing, checked beat by beat against an in-bench predictor.
// Depends on rgbyuv_pkg and the RTL top level only.

module rgb_to_yuv420_pixel_writer_unit_tb;

    localparam int unsigned POS_W       = rgbyuv_pkg::POS_W;
    localparam int unsigned COMP_W      = rgbyuv_pkg::COMP_W;
    localparam int unsigned DIM_W       = rgbyuv_pkg::DIM_W;
    localparam int unsigned LADDR_W     = rgbyuv_pkg::LADDR_W;
    localparam int unsigned CADDR_W     = rgbyuv_pkg::CADDR_W;
    localparam int unsigned CFG_IDX_W   = rgbyuv_pkg::CFG_IDX_W;
    localparam int unsigned IN_TDATA_W  = rgbyuv_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W = rgbyuv_pkg::OUT_TDATA_W;

    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int RANDOM_PER_SET = 60;

    // Input beat, laid out exactly as s_axis_tdata (red in the low byte)
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } pixel_beat_t;

    // Output beat, laid out exactly as m_axis_tdata (luma_value in the low byte)
    typedef struct packed {
        logic [5:0]         pad;
        logic [CADDR_W-1:0] v_address;
        logic [CADDR_W-1:0] u_address;
        logic [COMP_W-1:0]  v_value;
        logic [COMP_W-1:0]  u_value;
        logic [LADDR_W-1:0] luma_address;
        logic [COMP_W-1:0]  luma_value;
    } yuv_beat_t;

    typedef struct {
        yuv_beat_t data;
        logic      chroma_write;
    } yuv_result_t;

    // Scoreboard: mirrors the config registers and holds the expected result beats
    class yuv420_scoreboard;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             chroma_layout;
        yuv_result_t      expected_q[$];
        int               fail_count;

        function new();
            frame_width   = rgbyuv_pkg::FRAME_WIDTH_RST;
            frame_height  = rgbyuv_pkg::FRAME_HEIGHT_RST;
            chroma_layout = rgbyuv_pkg::LAYOUT_SEMI_PLANAR;
            fail_count    = 0;
        endfunction

        function void set_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic layout);
            frame_width   = w;
            frame_height  = h;
            chroma_layout = layout;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Compute the expected Y, U and V bytes and frame buffer addresses of one pixel
        function yuv_result_t convert_pixel(pixel_beat_t p);
            yuv_result_t     res;
            int              r, g, b;
            int              y_acc, u_acc, v_acc;
            longint unsigned w, h, col, row, plane, k, ua, va;
            r   = int'(p.red);
            g   = int'(p.green);
            b   = int'(p.blue);
            w   = longint'(frame_width);
            h   = longint'(frame_height);
            col = longint'(p.column);
            row = longint'(p.row);

            res.data = '0;
            y_acc = 66 * r + 129 * g + 25 * b + 128;
            res.data.luma_value   = COMP_W'((y_acc >> 8) + 16);
            res.data.luma_address = LADDR_W'(w * row + col);
            res.chroma_write      = (col[0] == 1'b0) && (row[0] == 1'b0);

            if (res.chroma_write)
            begin
                // Bias by 128 at bit 8 so the shift floors on a non-negative sum
                u_acc = -38 * r - 74 * g + 112 * b + 128 + 32768;
                v_acc = 112 * r - 94 * g - 18 * b + 128 + 32768;
                res.data.u_value = COMP_W'(u_acc >> 8);
                res.data.v_value = COMP_W'(v_acc >> 8);
                plane = w * h;
                k     = (row >> 1) * ((w + 1) >> 1) + (col >> 1);
                if (chroma_layout == rgbyuv_pkg::LAYOUT_SEMI_PLANAR)
                begin
                    ua = plane + 2 * k;
                    va = ua + 1;
                end
                else
                begin
                    ua = plane + (plane >> 2) + k;
                    va = plane + k;
                end
                res.data.u_address = CADDR_W'(ua);
                res.data.v_address = CADDR_W'(va);
            end
            return res;
        endfunction

        function void note_pixel(pixel_beat_t p);
            expected_q.push_back(convert_pixel(p));
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
            fail_count++;
        endtask

        // Compare one accepted result beat with the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            yuv_beat_t   got;
            yuv_result_t want;
            got = tdata;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected beat", 64'(tdata), 64'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.luma_value !== want.data.luma_value)
                report_mismatch("luma_value", 64'(got.luma_value), 64'(want.data.luma_value));
            if (got.luma_address !== want.data.luma_address)
                report_mismatch("luma_address", 64'(got.luma_address),
                                64'(want.data.luma_address));
            if (tuser !== want.chroma_write)
                report_mismatch("chroma_write", 64'(tuser), 64'(want.chroma_write));
            if (got.u_value !== want.data.u_value)
                report_mismatch("u_value", 64'(got.u_value), 64'(want.data.u_value));
            if (got.v_value !== want.data.v_value)
                report_mismatch("v_value", 64'(got.v_value), 64'(want.data.v_value));
            if (got.u_address !== want.data.u_address)
                report_mismatch("u_address", 64'(got.u_address), 64'(want.data.u_address));
            if (got.v_address !== want.data.v_address)
                report_mismatch("v_address", 64'(got.v_address), 64'(want.data.v_address));
            if (got.pad !== 6'd0)
                report_mismatch("padding", 64'(got.pad), 64'd0);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    yuv420_scoreboard sb;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    bit               hold_off_req = 1'b0;
    int               hold_left = 0;
    logic [POS_W-1:0] last_col = '0;
    logic [POS_W-1:0] last_row = '0;

    rgb_to_yuv420_pixel_writer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Check result beats, then drive ready: random stalls or a long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_LEN - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Write all three registers on consecutive edges, then drop the enable
    task apply_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic layout);
        cfg_we    <= 1'b1;
        cfg_index <= rgbyuv_pkg::REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= rgbyuv_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= rgbyuv_pkg::REG_CHROMA_LAYOUT;
        cfg_data  <= DIM_W'(layout);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(w, h, layout);
        @(posedge clk);
    endtask

    // Offer one pixel beat after a random gap and hold it until accepted
    task send_pixel(pixel_beat_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(p);
        last_col = p.column;
        last_row = p.row;
    endtask

    task send_at(int col, int row, int r, int g, int b);
        pixel_beat_t p;
        p.column = POS_W'(col);
        p.row    = POS_W'(row);
        p.red    = COMP_W'(r);
        p.green  = COMP_W'(g);
        p.blue   = COMP_W'(b);
        send_pixel(p);
    endtask

    function logic [COMP_W-1:0] pick_component();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COMP_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Random pixel: raster runs, in-frame jumps, full-range positions and frame edges
    task send_random_pixel();
        pixel_beat_t p;
        int          lim_c, lim_r;
        lim_c = (sb.frame_width >= 1 && sb.frame_width <= 4096) ? sb.frame_width - 1 : 4095;
        lim_r = (sb.frame_height >= 1 && sb.frame_height <= 4096) ? sb.frame_height - 1 : 4095;
        p.red   = pick_component();
        p.green = pick_component();
        p.blue  = pick_component();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                if (int'(last_col) >= lim_c)
                begin
                    p.column = '0;
                    p.row    = (int'(last_row) >= lim_r) ? '0 : last_row + 1'b1;
                end
                else
                begin
                    p.column = last_col + 1'b1;
                    p.row    = last_row;
                end
            end
            4, 5, 6, 7:
            begin
                p.column = POS_W'($urandom_range(0, lim_c));
                p.row    = POS_W'($urandom_range(0, lim_r));
            end
            8:
            begin
                p.column = POS_W'($urandom_range(0, 4095));
                p.row    = POS_W'($urandom_range(0, 4095));
            end
            default:
            begin
                p.column = ($urandom_range(0, 1) == 1) ? POS_W'(lim_c) : POS_W'(4095);
                p.row    = ($urandom_range(0, 1) == 1) ? POS_W'(lim_r) : POS_W'(4094);
            end
        endcase
        send_pixel(p);
    endtask

    // Drop valid and wait until every expected beat has come back
    task drain_pipeline();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (6) @(posedge clk);
    endtask

    // Watchdog
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence: reset, directed beats, then one random set per configuration
    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset configuration, no idling: color extremes and chroma parity
        send_at(0, 0, 0, 0, 0);
        send_at(1, 0, 255, 255, 255);
        send_at(0, 1, 255, 0, 0);
        send_at(1, 1, 0, 255, 0);
        send_at(2, 2, 0, 0, 255);
        send_at(2, 2, 255, 255, 0);
        send_at(4, 0, 0, 255, 255);
        send_at(0, 4, 255, 0, 255);
        send_at(638, 478, 128, 128, 128);
        send_at(639, 479, 1, 254, 127);
        // Positions beyond the frame
        send_at(4095, 4095, 255, 255, 255);
        send_at(4094, 4094, 0, 0, 255);
        send_at(4094, 0, 255, 255, 0);
        send_at(0, 4094, 170, 85, 60);
        repeat (RANDOM_PER_SET) send_random_pixel();

        for (int set_id = 1; set_id < 8; set_id++)
        begin
            drain_pipeline();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case (set_id)
                1:
                begin
                    apply_config(13'd2, 13'd2, rgbyuv_pkg::LAYOUT_PLANAR);
                    send_idle_pct = 74;
                end
                2:
                begin
                    apply_config(13'd4096, 13'd4096, rgbyuv_pkg::LAYOUT_SEMI_PLANAR);
                    recv_stall_pct = 74;
                    hold_off_req   = 1'b1;
                end
                3:
                begin
                    apply_config(13'd4096, 13'd4096, rgbyuv_pkg::LAYOUT_PLANAR);
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
                4:
                begin
                    // Largest register values: addresses wrap
                    apply_config(13'd8191, 13'd8191, rgbyuv_pkg::LAYOUT_PLANAR);
                end
                5:
                begin
                    // Odd frame size is used as given
                    apply_config(13'd1, 13'd3, rgbyuv_pkg::LAYOUT_SEMI_PLANAR);
                    send_idle_pct = 74;
                end
                6:
                begin
                    apply_config(DIM_W'(2 * $urandom_range(1, 32)),
                                 DIM_W'(2 * $urandom_range(1, 32)),
                                 1'($urandom_range(0, 1)));
                    recv_stall_pct = 74;
                end
                default:
                begin
                    apply_config(13'd1920, 13'd1080, rgbyuv_pkg::LAYOUT_PLANAR);
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            send_at(0, 0, 255, 255, 255);
            send_at(4094, 4094, 0, 0, 0);
            repeat (RANDOM_PER_SET) send_random_pixel();
        end

        drain_pipeline();
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
